// ===== rtl/nnt_pkg.sv =====
// ----------------------------------------------------------------------------
// nnt_pkg: shared types and constants for the nearest-neighbor tour block
// Widths of the request and result fields, and the control/status structs
// that pass between the sequencer and the compare/accumulate unit.
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int MAX_CITIES = 32;
  localparam int IDX_W      = $clog2(MAX_CITIES);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DIST_W     = 24;
  localparam int COST_W     = 29;
  localparam int CNT_W      = 6;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CITIES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [COST_W-1:0] cost_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Sequencer to compare/accumulate unit.
  typedef struct packed {
    logic clear_best;
    logic cmp_vld;
    idx_t cmp_idx;
    logic clear_cost;
    logic add_best;
    logic add_ret;
    logic ret_dbl;
  } ctl_t;

  // Compare/accumulate unit back to the sequencer.
  typedef struct packed {
    logic  found;
    idx_t  best_idx;
    dist_t best_dist;
    cost_t cost_sum;
  } sts_t;

  // Map a raw city count onto the supported range 1..MAX_CITIES.
  function automatic cnt_t clamp_count(input cnt_t raw);
    cnt_t res;
    res = raw;
    if (raw == '0) begin
      res = CNT_ONE;
    end else if (raw > CNT_MAX) begin
      res = CNT_MAX;
    end
    return res;
  endfunction

endpackage

// ===== rtl/nnt_ifs.sv =====
// ----------------------------------------------------------------------------
// nnt_ifs: handshake channels of the nearest-neighbor tour block
// Request channel (matrix entries), result channel (tour cities) and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface nnt_req_if;
  logic                        valid;
  logic                        ready;
  logic [nnt_pkg::IDX_W-1:0]   row_city;
  logic [nnt_pkg::IDX_W-1:0]   col_city;
  logic [nnt_pkg::DIST_W-1:0]  distance;
  logic                        last_entry;

  modport source (output valid, row_city, col_city, distance, last_entry, input ready);
  modport sink   (input valid, row_city, col_city, distance, last_entry, output ready);
endinterface

interface nnt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [nnt_pkg::IDX_W-1:0]   tour_position;
  logic [nnt_pkg::IDX_W-1:0]   city;
  logic [nnt_pkg::COST_W-1:0]  tour_cost;
  logic                        last_of_tour;

  modport source (output valid, tour_position, city, tour_cost, last_of_tour, input ready);
  modport sink   (input valid, tour_position, city, tour_cost, last_of_tour, output ready);
endinterface

interface nnt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [nnt_pkg::CNT_W-1:0]   city_count;

  modport source (output valid, city_count, input ready);
  modport sink   (input valid, city_count, output ready);
endinterface

// ===== rtl/nearest_neighbor_tour_top.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_top: greedy nearest-neighbor tour engine
// Loads a distance matrix entry by entry and, after the last entry, walks
// a nearest-neighbor tour from city 0, returning one city per result and
// the closed-tour cost on the final one.
// ----------------------------------------------------------------------------
//
//   channel  role    carries
//   -------  ------  -----------------------------------------------------
//   req      sink    row_city, col_city, distance, last_entry (one entry)
//   rsp      source  tour_position, city, tour_cost, last_of_tour
//   cfg      sink    city_count (write only, always ready)
//
// A request with last_entry starts the tour. The one read port of the
// distance store is walked one row entry per cycle for every tour step,
// and req.ready is low meanwhile.
// Reset: rst is synchronous; it returns the sequencer to idle and the city
// count to 32. The distance store is not cleared and needs no clearing pass.
// Stalls: a held rsp freezes the sequencer at its next result.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour_top (
  input logic       clk,
  input logic       rst,
  nnt_req_if.sink   req,
  nnt_rsp_if.source rsp,
  nnt_cfg_if.sink   cfg
);
  import nnt_pkg::*;

  cnt_t  n_eff;
  ctl_t  ctl;
  sts_t  sts;
  dist_t rd_data;

  // Hold the clamped city count; the user must write it only between tours, the block does not enforce it.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_eff <= CNT_MAX;
    end else if (cfg.valid && cfg.ready) begin
      n_eff <= clamp_count(cfg.city_count);
    end
  end

  // Sequencer with the distance store and the result register.
  nnt_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .n_eff   (n_eff),
    .req     (req),
    .rsp     (rsp),
    .ctl     (ctl),
    .sts     (sts),
    .rd_data (rd_data)
  );

  // Shared compare and cost adder, fed straight from the store read port.
  nnt_min_unit u_min (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_data (rd_data),
    .sts     (sts)
  );

endmodule

// ===== rtl/nnt_min_unit.sv =====
// ----------------------------------------------------------------------------
// nnt_min_unit: shared compare and cost accumulator
// Tracks the nearest unvisited city of the running scan and sums the
// tour cost through one adder.
// ----------------------------------------------------------------------------
module nnt_min_unit (
  input  logic           clk,
  input  logic           rst,
  input  nnt_pkg::ctl_t  ctl,
  input  nnt_pkg::dist_t rd_data,
  output nnt_pkg::sts_t  sts
);
  import nnt_pkg::*;

  logic  found;
  idx_t  best_idx;
  dist_t best_dist;
  cost_t cost_sum;
  cost_t add_opd;

  // Strict less-than keeps the lowest index on a tie.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear_best) begin
      found <= 1'b0;
    end else if (ctl.cmp_vld && (!found || rd_data < best_dist)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_vld && (!found || rd_data < best_dist)) begin
      best_idx  <= ctl.cmp_idx;
      best_dist <= rd_data;
    end
  end

  always_comb begin
    if (ctl.add_ret) begin
      add_opd = ctl.ret_dbl ? {(COST_W-DIST_W-1)'(0), rd_data, 1'b0}
                            : {(COST_W-DIST_W)'(0), rd_data};
    end else begin
      add_opd = {(COST_W-DIST_W)'(0), best_dist};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_sum <= '0;
    end else if (ctl.clear_cost) begin
      cost_sum <= '0;
    end else if (ctl.add_best || ctl.add_ret) begin
      cost_sum <= cost_sum + add_opd;
    end
  end

  assign sts = '{found: found, best_idx: best_idx, best_dist: best_dist,
                 cost_sum: cost_sum};

endmodule

// ===== rtl/nnt_seq.sv =====
// ----------------------------------------------------------------------------
// nnt_seq: distance store and tour sequencer
// Stores matrix entries, scans one row entry per cycle for each tour step
// and drives the result register.
// ----------------------------------------------------------------------------
module nnt_seq (
  input  logic          clk,
  input  logic          rst,
  input  nnt_pkg::cnt_t n_eff,
  nnt_req_if.sink       req,
  nnt_rsp_if.source     rsp,
  output nnt_pkg::ctl_t ctl,
  input  nnt_pkg::sts_t sts,
  output nnt_pkg::dist_t rd_data
);
  import nnt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_HEAD     = 9'b000000010,
    S_SCAN     = 9'b000000100,
    S_DRAIN    = 9'b000001000,
    S_PICK     = 9'b000010000,
    S_EMIT     = 9'b000100000,
    S_RET_RD   = 9'b001000000,
    S_RET_WAIT = 9'b010000000,
    S_TAIL     = 9'b100000000
  } state_t;

  state_t               state;
  logic [MAX_CITIES-1:0] visited;
  idx_t                 cur;
  idx_t                 step;
  idx_t                 scan_idx;
  logic                 cmp_vld;
  idx_t                 cmp_idx;
  idx_t                 n_m1;
  logic                 n_is1;
  logic                 n_is2;
  logic                 req_fire;
  logic                 out_free;
  logic                 load_out;
  addr_t                rd_addr;

  assign n_m1     = IDX_W'(n_eff - CNT_ONE);
  assign n_is1    = (n_eff == CNT_ONE);
  assign n_is2    = (n_eff == CNT_TWO);
  assign req.ready = (state == S_IDLE);
  assign req_fire = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign load_out = out_free && (state == S_HEAD || state == S_EMIT || state == S_TAIL);

  always_comb begin
    if (state == S_RET_RD) begin
      rd_addr = n_is2 ? {IDX_W'(0), IDX_W'(1)} : {cur, IDX_W'(0)};
    end else begin
      rd_addr = {cur, scan_idx};
    end
  end

  nnt_dist_ram u_ram (
    .clk     (clk),
    .wr_en   (req_fire),
    .wr_addr ({req.row_city, req.col_city}),
    .wr_data (req.distance),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      visited <= '0;
      cur     <= '0;
      step    <= '0;
      scan_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire && req.last_entry) begin
            visited <= MAX_CITIES'(1);
            cur     <= '0;
            step    <= IDX_W'(1);
            state   <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (out_free) begin
            scan_idx <= '0;
            if (n_is1) begin
              state <= S_IDLE;
            end else if (n_is2) begin
              cur   <= IDX_W'(1);
              state <= S_RET_RD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_idx == n_m1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_PICK;
        end
        S_PICK: begin
          visited[sts.best_idx] <= 1'b1;
          cur <= sts.best_idx;
          state <= (step == n_m1) ? S_RET_RD : S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            step     <= step + IDX_W'(1);
            scan_idx <= '0;
            state    <= S_SCAN;
          end
        end
        S_RET_RD: begin
          state <= S_RET_WAIT;
        end
        S_RET_WAIT: begin
          state <= S_TAIL;
        end
        S_TAIL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Compare pipe: lines up with the registered read of the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= (state == S_SCAN) && !visited[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
  end

  assign ctl = '{
    clear_best: (state == S_HEAD) || (state == S_EMIT),
    cmp_vld:    cmp_vld,
    cmp_idx:    cmp_idx,
    clear_cost: req_fire,
    add_best:   (state == S_PICK),
    add_ret:    (state == S_RET_WAIT),
    ret_dbl:    n_is2
  };

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      unique case (state)
        S_HEAD: begin
          rsp.tour_position <= '0;
          rsp.city          <= '0;
          rsp.tour_cost     <= '0;
          rsp.last_of_tour  <= n_is1;
        end
        S_EMIT: begin
          rsp.tour_position <= step;
          rsp.city          <= cur;
          rsp.tour_cost     <= '0;
          rsp.last_of_tour  <= 1'b0;
        end
        default: begin
          rsp.tour_position <= n_m1;
          rsp.city          <= cur;
          rsp.tour_cost     <= sts.cost_sum;
          rsp.last_of_tour  <= 1'b1;
        end
      endcase
    end
  end

  a_pick_found: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK |-> sts.found)
    else $error("tour step picked with no candidate city");

  a_cmp_unvisited: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> !visited[cmp_idx])
    else $error("visited city entered the compare");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out && rsp.valid |-> rsp.ready)
    else $error("result register overwritten before it was taken");

endmodule

// ===== rtl/nnt_dist_ram.sv =====
// ----------------------------------------------------------------------------
// nnt_dist_ram: distance matrix store
// One write port and one registered read port, row-major by city pair.
// ----------------------------------------------------------------------------
module nnt_dist_ram (
  input  logic           clk,
  input  logic           wr_en,
  input  nnt_pkg::addr_t wr_addr,
  input  nnt_pkg::dist_t wr_data,
  input  nnt_pkg::addr_t rd_addr,
  output nnt_pkg::dist_t rd_data
);
  import nnt_pkg::*;

  dist_t mem [MAX_CITIES*MAX_CITIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== test/nnt_tour_checker.sv =====
// ----------------------------------------------------------------------------
// nnt_tour_checker: tour predictor and scoreboard for the tour engine
// Keeps its own copy of the distance store and city count from the accepted
// requests and count writes. Plans the greedy tour on each last entry and
// compares each accepted result with the oldest planned tour stop.
// ----------------------------------------------------------------------------
module nnt_tour_checker (
  input  logic clk,
  input  logic rst,
  nnt_req_if   req,
  nnt_rsp_if   rsp,
  nnt_cfg_if   cfg,
  output int   mismatches,
  output int   pending
);
  import nnt_pkg::*;

  typedef struct packed {
    idx_t  pos;
    idx_t  city;
    cost_t cost;
    logic  last;
  } tour_stop_t;

  dist_t      dist_copy [MAX_CITIES*MAX_CITIES];
  cnt_t       count_copy;
  tour_stop_t tour_stops_q [$];

  function automatic dist_t lookup(input idx_t r, input idx_t c);
    return dist_copy[{r, c}];
  endfunction

  function automatic tour_stop_t make_stop(input idx_t pos, input idx_t city,
                                           input cost_t cost, input logic last);
    tour_stop_t s;
    s.pos  = pos;
    s.city = city;
    s.cost = cost;
    s.last = last;
    return s;
  endfunction

  // Greedy walk from city 0; lowest index wins a tie.
  task automatic plan_tour();
    int              n;
    logic            seen [MAX_CITIES];
    idx_t            here;
    idx_t            best;
    dist_t           best_d;
    dist_t           dd;
    logic            found;
    logic [COST_W:0] total;
    n = int'(count_copy);
    if (n == 0) n = 1;
    if (n > MAX_CITIES) n = MAX_CITIES;
    if (n == 1) begin
      tour_stops_q.push_back(make_stop('0, '0, '0, 1'b1));
      return;
    end
    if (n == 2) begin
      total = (COST_W+1)'({lookup('0, idx_t'(1)), 1'b0});
      tour_stops_q.push_back(make_stop('0, '0, '0, 1'b0));
      tour_stops_q.push_back(make_stop(idx_t'(1), idx_t'(1), total[COST_W-1:0], 1'b1));
      return;
    end
    foreach (seen[i]) seen[i] = 1'b0;
    seen[0] = 1'b1;
    here    = '0;
    total   = '0;
    tour_stops_q.push_back(make_stop('0, '0, '0, 1'b0));
    for (int step = 1; step < n; step++) begin
      found  = 1'b0;
      best   = '0;
      best_d = '0;
      for (int i = 0; i < n; i++) begin
        if (!seen[i]) begin
          dd = lookup(here, idx_t'(i));
          if (!found || dd < best_d) begin
            found  = 1'b1;
            best   = idx_t'(i);
            best_d = dd;
          end
        end
      end
      seen[best] = 1'b1;
      total      = total + (COST_W+1)'(best_d);
      here       = best;
      if (step + 1 < n) tour_stops_q.push_back(make_stop(idx_t'(step), best, '0, 1'b0));
    end
    total = total + (COST_W+1)'(lookup(here, '0));
    tour_stops_q.push_back(make_stop(idx_t'(n - 1), here, total[COST_W-1:0], 1'b1));
  endtask

  always @(posedge clk) begin
    tour_stop_t got;
    tour_stop_t want;
    logic       stray;
    if (rst) begin
      count_copy = CNT_MAX;
      tour_stops_q.delete();
      mismatches = 0;
      pending   <= 0;
    end else begin
      if (cfg.valid && cfg.ready) count_copy = cfg.city_count;
      if (rsp.valid && rsp.ready) begin
        got   = make_stop(rsp.tour_position, rsp.city, rsp.tour_cost, rsp.last_of_tour);
        stray = (tour_stops_q.size() == 0);
        want  = '0;
        if (!stray) want = tour_stops_q.pop_front();
        if (stray || got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            if (stray)
              $display("%0t nnt_tour_checker: unexpected result pos=%0d city=%0d cost=%0d last=%0b",
                       $time, got.pos, got.city, got.cost, got.last);
            else begin
              $write("%0t nnt_tour_checker: expected pos=%0d city=%0d cost=%0d last=%0b",
                     $time, want.pos, want.city, want.cost, want.last);
              $display(", got pos=%0d city=%0d cost=%0d last=%0b",
                       got.pos, got.city, got.cost, got.last);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        dist_copy[{req.row_city, req.col_city}] = req.distance;
        if (req.last_entry) plan_tour();
      end
      pending <= tour_stops_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: top-level testbench of the nearest-neighbor tour engine
// Loads small distance matrices under a range of city counts, from one
// city upward, and lets each last entry start a tour. A checker beside the
// block predicts every tour stop; this module only drives the channels,
// with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb;
  import nnt_pkg::*;

  typedef enum int {DIST_FULL, DIST_TIES, DIST_EDGES, DIST_FLAT} dist_style_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_BLINK} rx_mode_e;

  localparam int SQUEEZE_CYCLES = 400;
  localparam int TAIL_CYCLES    = 200;
  localparam int RANDOM_ENTRIES = 120;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   pending;

  // Sender bookkeeping: burst state, request count, and which store
  // entries hold data, so that no tour reads an entry never written.
  int   burst_left    = 0;
  int   entries_sent  = 0;
  int   active_cities = MAX_CITIES;
  bit   written [MAX_CITIES*MAX_CITIES];

  // Raised once to make the receiver hold off for a long stretch.
  logic squeeze_go = 1'b0;

  nnt_req_if req_ch ();
  nnt_rsp_if rsp_ch ();
  nnt_cfg_if cfg_ch ();

  nearest_neighbor_tour_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  nnt_tour_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #1000000;
    $display("tb: errors");
    $finish;
  end

  // Result receiver: switch between random stall patterns, and hold ready low
  // for one long stretch when asked.
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       phase;
    bit       squeezed;
    rsp_ch.ready <= 1'b0;
    mode     = RX_OPEN;
    span     = 0;
    phase    = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_go && !squeezed) begin
        // Block fills, freezes at its next result and stalls its input.
        squeezed = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES - 1) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          span = $urandom_range(4, 60);
        end
        span--;
        phase++;
        case (mode)
          RX_OPEN:  rsp_ch.ready <= 1'b1;
          RX_COIN:  rsp_ch.ready <= 1'($urandom_range(0, 1));
          RX_SLOW:  rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default:  rsp_ch.ready <= phase[1];
        endcase
      end
    end
  end

  function automatic dist_t pick_distance(input dist_style_e style);
    dist_t d;
    case (style)
      DIST_TIES: d = dist_t'($urandom_range(0, 2));
      DIST_EDGES: begin
        case ($urandom_range(0, 3))
          0:       d = '0;
          1:       d = '1;
          2:       d = dist_t'(1);
          default: d = dist_t'($urandom);
        endcase
      end
      DIST_FLAT: d = '0;
      default:   d = dist_t'($urandom);
    endcase
    return d;
  endfunction

  // Offer one request and hold it until accepted. Between bursts, drop
  // valid for a random gap; some bursts run long with no gaps at all.
  task automatic send_entry(input idx_t r, input idx_t c, input dist_t d, input logic last);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(40, 120);
      else burst_left = $urandom_range(1, 16);
    end
    req_ch.valid      <= 1'b1;
    req_ch.row_city   <= r;
    req_ch.col_city   <= c;
    req_ch.distance   <= d;
    req_ch.last_entry <= last;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    written[{r, c}] = 1'b1;
    entries_sent++;
  endtask

  // Drop valid and wait until every planned tour stop has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write the city count while the block is idle.
  task automatic set_count(input cnt_t value);
    wait_drained();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.city_count <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (value == '0) active_cities = 1;
    else if (value > CNT_MAX) active_cities = MAX_CITIES;
    else active_cities = int'(value);
  endtask

  // Write the n x n corner of the matrix: all of it, or only the holes.
  task automatic load_block(input int n, input dist_style_e style, input bit rewrite);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (rewrite || !written[r*MAX_CITIES + c])
          send_entry(idx_t'(r), idx_t'(c), pick_distance(style), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int          n;
    int          pick;
    int          base;
    dist_style_e style;
    cnt_t        value;
    req_ch.valid      <= 1'b0;
    req_ch.row_city   <= '0;
    req_ch.col_city   <= '0;
    req_ch.distance   <= '0;
    req_ch.last_entry <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.city_count <= '0;
    wait (rst === 1'b0);
    @(posedge clk);

    // One city, as count 1 and as count 0: tour [0] at zero cost. The last
    // entry lands in the far corner with the widest distance.
    set_count(CNT_ONE);
    send_entry('1, '1, '1, 1'b1);
    set_count('0);
    send_entry('0, '0, '0, 1'b1);

    // Two cities: cost is twice d(0,1). The second tour follows right
    // behind the first and only rewrites d(1,0), which must not matter.
    set_count(CNT_TWO);
    send_entry('0, idx_t'(1), '1, 1'b1);
    send_entry(idx_t'(1), '0, '0, 1'b1);

    // Three cities, all distances equal: ties go to the lowest index.
    set_count(cnt_t'(3));
    load_block(3, DIST_FLAT, 1'b1);
    send_entry(idx_t'(2), idx_t'(2), '0, 1'b1);

    // Stall the receiver while the next tour's entries are already queued.
    squeeze_go <= 1'b1;
    load_block(3, DIST_EDGES, 1'b1);
    send_entry(idx_t'(2), '0, '1, 1'b1);

    // Random small tours. A count write only comes with an idle block;
    // otherwise tours run back to back.
    base = entries_sent;
    while (entries_sent - base < RANDOM_ENTRIES) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) n = $urandom_range(1, 4);
      else if (pick < 9) n = $urandom_range(5, 6);
      else n = $urandom_range(7, 8);
      style = dist_style_e'($urandom_range(0, 3));
      value = cnt_t'(n);
      if (n == 1 && $urandom_range(0, 1) == 1) value = '0;
      if (n != active_cities || $urandom_range(0, 2) == 0) set_count(value);

      // Mostly a fresh matrix; otherwise fill the holes and touch a few entries.
      if ($urandom_range(0, 2) != 0) begin
        load_block(n, style, 1'b1);
      end else begin
        load_block(n, style, 1'b0);
        repeat ($urandom_range(1, 4))
          send_entry(idx_t'($urandom_range(0, n - 1)), idx_t'($urandom_range(0, n - 1)),
                     pick_distance(style), 1'b0);
      end

      // Noise: stray writes anywhere in the store.
      repeat ($urandom_range(0, 3))
        send_entry(idx_t'($urandom), idx_t'($urandom), dist_t'($urandom), 1'b0);

      // The last entry mostly lands inside the live corner.
      if ($urandom_range(0, 3) != 0)
        send_entry(idx_t'($urandom_range(0, n - 1)), idx_t'($urandom_range(0, n - 1)),
                   pick_distance(style), 1'b1);
      else
        send_entry(idx_t'($urandom), idx_t'($urandom), dist_t'($urandom), 1'b1);
    end

    // Drain, then leave room for any stray result before the verdict.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/nnt_pkg.sv
rtl/nnt_ifs.sv
rtl/nnt_min_unit.sv
rtl/nnt_seq.sv
rtl/nnt_dist_ram.sv
rtl/nearest_neighbor_tour_top.sv
test/nnt_tour_checker.sv
test/tb.sv
